// ----- hdl/fdcl_pkg.sv -----
// shared types, constants and helper functions for the density constraint lambda unit
// no dependencies; imported by every module of the block

package fdcl_pkg;

  localparam int W  = 48;        // word width
  localparam int F  = 32;        // fraction bits
  localparam int MW = W - 1;     // magnitude width
  localparam int PW = 2 * W;     // full product width
  localparam int HW = W / 2;     // partial product operand width
  localparam int NW = W + F;     // dividend width after scaling
  localparam int QDEPTH = 2;     // queue between front and back
  localparam int CFG_IW = 3;     // register index width

  localparam logic [MW-1:0] MAGMAX = {MW{1'b1}};
  localparam logic [W-1:0]  ONE_FIX = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic [MW-1:0] DIST_BIAS =
    MW'(((64'd1 << F) + 64'd5000000) / 64'd10000000);

  localparam logic [CFG_IW-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POLY6    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SPIKY    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INV_REST = 3'd3;
  localparam logic [CFG_IW-1:0] REG_EPSILON  = 3'd4;

  localparam logic [MW-1:0] RST_RADIUS   = 47'd2147483648;
  localparam logic [MW-1:0] RST_POLY6    = 47'd3445168077000;
  localparam logic [MW-1:0] RST_SPIKY    = 47'd3937333966400;
  localparam logic [MW-1:0] RST_INV_REST = 47'd4294967;
  localparam logic [MW-1:0] RST_EPSILON  = 47'd214748364800;

  typedef logic [W-1:0]  word_t;
  typedef logic [MW-1:0] mag_t;
  typedef logic [PW-1:0] prod_t;

  typedef struct packed {
    word_t mx;
    word_t my;
    word_t mz;
    logic  nx;
    logic  ny;
    logic  nz;
    mag_t  mass;
    logic  is_self;
    logic  last_neighbor;
  } item_t;

  typedef struct packed {
    mag_t radius;
    mag_t poly6;
    mag_t spiky;
    mag_t inv_rest;
    mag_t epsilon;
  } cfg_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    prod_t prod;
  } mul_rsp_t;

  typedef struct packed {
    logic  start;
    prod_t rad;
  } sqrt_req_t;

  typedef struct packed {
    logic  done;
    word_t root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic  start;
    word_t num;
    mag_t  den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    mag_t quo;
  } div_rsp_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sadd_t;

  // signed add clamped to the word range
  function automatic sadd_t sadd(word_t a, word_t b);
    logic [W:0] s;
    sadd_t r;
    s = {a[W-1], a} + {b[W-1], b};
    r.sat = s[W] ^ s[W-1];
    if (r.sat) begin
      r.val = s[W] ? {1'b1, {MW{1'b0}}} : {1'b0, {MW{1'b1}}};
    end else begin
      r.val = s[W-1:0];
    end
    return r;
  endfunction

  function automatic word_t abs_word(word_t v);
    return v[W-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage

// ----- hdl/fdcl_front.sv -----
// front end: takes neighbour beats, splits offsets into sign and magnitude, queues them
// depends on fdcl_pkg

module fdcl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [fdcl_pkg::W-1:0]  rel_x_i,
  input  logic [fdcl_pkg::W-1:0]  rel_y_i,
  input  logic [fdcl_pkg::W-1:0]  rel_z_i,
  input  logic [fdcl_pkg::MW-1:0] mass_i,
  input  logic                    is_self_i,
  input  logic                    last_neighbor_i,
  output fdcl_pkg::item_t         head_o,
  output logic                    head_valid_o,
  input  logic                    pop_i
);
  import fdcl_pkg::*;

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  item_t          q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0] cnt_q;
  item_t          in_item;
  logic           push, pop;

  always_comb begin
    in_item.mx            = abs_word(rel_x_i);
    in_item.my            = abs_word(rel_y_i);
    in_item.mz            = abs_word(rel_z_i);
    in_item.nx            = rel_x_i[W-1];
    in_item.ny            = rel_y_i[W-1];
    in_item.nz            = rel_z_i[W-1];
    in_item.mass          = mass_i;
    in_item.is_self       = is_self_i;
    in_item.last_neighbor = last_neighbor_i;
  end

  assign busy_o       = (cnt_q == QCW'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = q_mem[rd_ptr_q];
  assign push         = start_i && !busy_o;
  assign pop          = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QAW'(1);
      if (push && !pop)      cnt_q <= cnt_q + QCW'(1);
      else if (pop && !push) cnt_q <= cnt_q - QCW'(1);
    end
  end

endmodule

// ----- hdl/fdcl_mul.sv -----
// shared multiplier: full word by word product from four half-width partial products
// depends on fdcl_pkg

module fdcl_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fdcl_pkg::mul_req_t req_i,
  output fdcl_pkg::mul_rsp_t rsp_o
);
  import fdcl_pkg::*;

  localparam int PARTS = 4;

  word_t          a_q, b_q;
  prod_t          acc_q, pp_shift;
  logic [W-1:0]   pp_q;
  logic [1:0]     sh_q;
  logic [2:0]     cnt_q;
  logic           run_q, ppv_q, done_q;
  logic [HW-1:0]  a_half, b_half;

  always_comb begin
    a_half = cnt_q[0] ? a_q[W-1:HW] : a_q[HW-1:0];
    b_half = cnt_q[1] ? b_q[W-1:HW] : b_q[HW-1:0];
    case (sh_q)
      2'd0:    pp_shift = PW'(pp_q);
      2'd1:    pp_shift = PW'(pp_q) << HW;
      default: pp_shift = PW'(pp_q) << (2 * HW);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q != 3'(PARTS)) begin
        pp_q <= a_half * b_half;
        sh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
      end
      if (ppv_q) acc_q <= acc_q + pp_shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        run_q <= 1'b1;
        ppv_q <= 1'b0;
      end else if (run_q) begin
        if (cnt_q != 3'(PARTS)) begin
          cnt_q <= cnt_q + 3'd1;
          ppv_q <= 1'b1;
        end else begin
          // last partial product lands in the accumulator this cycle
          ppv_q  <= 1'b0;
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

// ----- hdl/fdcl_sqrt.sv -----
// floor integer square root of a double-width radicand, one root bit per cycle
// depends on fdcl_pkg

module fdcl_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdcl_pkg::sqrt_req_t req_i,
  output fdcl_pkg::sqrt_rsp_t rsp_o
);
  import fdcl_pkg::*;

  localparam int CW = $clog2(W);

  prod_t          rad_q;
  logic [W:0]     rem_q;
  word_t          root_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [W+2:0]   rem2, trial, diff;
  logic           ge;

  always_comb begin
    rem2  = {rem_q, rad_q[PW-1:PW-2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (rem2 >= trial);
    diff  = rem2 - trial;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[W:0] : rem2[W:0];
      root_q <= {root_q[W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ----- hdl/fdcl_div.sv -----
// restoring divider for (num << F) / den, one quotient bit per cycle, clamps to the magnitude range
// depends on fdcl_pkg

module fdcl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fdcl_pkg::div_req_t req_i,
  output fdcl_pkg::div_rsp_t rsp_o
);
  import fdcl_pkg::*;

  localparam int CW = $clog2(NW);

  logic [NW-1:0]  n_q, quo_q;
  mag_t           rem_q, den_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [W-1:0]   rem2, diff;
  logic           ge;

  always_comb begin
    rem2 = {rem_q, n_q[NW-1]};
    ge   = (rem2 >= {1'b0, den_q});
    diff = rem2 - {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= {req_i.num, {F{1'b0}}};
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      n_q   <= n_q << 1;
      rem_q <= ge ? diff[MW-1:0] : rem2[MW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = |quo_q[NW-1:MW];
  assign rsp_o.quo  = rsp_o.sat ? MAGMAX : quo_q[MW-1:0];

endmodule

// ----- hdl/fdcl_back.sv -----
// back end: sequences kernel, gradient and lambda arithmetic over the shared units
// depends on fdcl_pkg; drives fdcl_mul, fdcl_sqrt and fdcl_div

module fdcl_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fdcl_pkg::cfg_t          cfg_i,
  input  fdcl_pkg::item_t         head_i,
  input  logic                    head_valid_i,
  output logic                    pop_o,
  output fdcl_pkg::mul_req_t      mul_req_o,
  input  fdcl_pkg::mul_rsp_t      mul_rsp_i,
  output fdcl_pkg::sqrt_req_t     sqrt_req_o,
  input  fdcl_pkg::sqrt_rsp_t     sqrt_rsp_i,
  output fdcl_pkg::div_req_t      div_req_o,
  input  fdcl_pkg::div_rsp_t      div_rsp_i,
  output logic                    res_valid_o,
  output logic [fdcl_pkg::W-1:0]  lambda_o,
  output logic [fdcl_pkg::MW-1:0] density_o,
  output logic                    saturated_o
);
  import fdcl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_WAIT, ST_SQ1, ST_SQ2, ST_SQ3, ST_RAD, ST_HH, ST_RR, ST_D2, ST_D3,
    ST_PW, ST_DM, ST_HR, ST_SC, ST_QT, ST_GX1, ST_GX2, ST_GY1, ST_GY2, ST_GZ1,
    ST_GZ2, ST_A1, ST_A2, ST_A3, ST_A4, ST_FIN, ST_G1, ST_G2, ST_G3, ST_GM,
    ST_GG, ST_GS, ST_CD, ST_LD, ST_EMIT
  } state_e;

  state_e    state_q, ret_q;
  item_t     it_q;
  mul_req_t  mul_q;
  sqrt_req_t sqrt_q;
  div_req_t  div_q;
  prod_t     s_q;
  word_t     r_q, dsum_q, gsx_q, gsy_q, gsz_q, gss_q, lambda_q;
  mag_t      tmp_q, d_q, q_q, denom_q, lm_q, density_q;
  logic      ovf_q, lneg_q, res_valid_q, sat_q;

  // helpers
  mag_t   fm, d_now, hr, den_now, gm, dens;
  logic   fm_sat, gm_sat, unit_done;
  word_t  fm_w, neg_fm, den_sum, c_val, cm;
  sadd_t  add_d, add_x, add_y, add_z, add_g, add_s2, add_c;

  always_comb begin
    fm_sat    = |mul_rsp_i.prod[PW-1:F+MW];
    fm        = fm_sat ? MAGMAX : mul_rsp_i.prod[F+MW-1:F];
    fm_w      = {1'b0, fm};
    neg_fm    = ~fm_w + word_t'(1);
    d_now     = tmp_q - fm;
    hr        = cfg_i.radius - r_q[MW-1:0];
    den_sum   = {1'b0, r_q[MW-1:0]} + {1'b0, DIST_BIAS};
    den_now   = den_sum[W-1] ? MAGMAX : den_sum[MW-1:0];
    gm_sat    = sqrt_rsp_i.root[W-1];
    gm        = gm_sat ? MAGMAX : sqrt_rsp_i.root[MW-1:0];
    dens      = dsum_q[W-1] ? '0 : dsum_q[MW-1:0];
    add_d     = sadd(dsum_q, fm_w);
    // gradient points against the offset
    add_x     = sadd(gsx_q, it_q.nx ? fm_w : neg_fm);
    add_y     = sadd(gsy_q, it_q.ny ? fm_w : neg_fm);
    add_z     = sadd(gsz_q, it_q.nz ? fm_w : neg_fm);
    add_g     = sadd(gss_q, fm_w);
    add_s2    = sadd(add_g.val, {1'b0, cfg_i.epsilon});
    add_c     = sadd(fm_w, ~ONE_FIX + word_t'(1));
    c_val     = add_c.val;
    cm        = abs_word(c_val);
    unit_done = mul_rsp_i.done || sqrt_rsp_i.done || div_rsp_i.done;
  end

  assign pop_o = (state_q == ST_IDLE) && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_q        <= ST_IDLE;
      mul_q.start  <= 1'b0;
      sqrt_q.start <= 1'b0;
      div_q.start  <= 1'b0;
      res_valid_q  <= 1'b0;
      dsum_q       <= '0;
      gsx_q        <= '0;
      gsy_q        <= '0;
      gsz_q        <= '0;
      gss_q        <= '0;
      ovf_q        <= 1'b0;
    end else begin
      mul_q.start  <= 1'b0;
      sqrt_q.start <= 1'b0;
      div_q.start  <= 1'b0;
      res_valid_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            it_q    <= head_i;
            mul_q   <= '{start: 1'b1, a: head_i.mx, b: head_i.mx};
            ret_q   <= ST_SQ1;
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (unit_done) state_q <= ret_q;
        end
        ST_SQ1: begin
          s_q     <= mul_rsp_i.prod;
          mul_q   <= '{start: 1'b1, a: it_q.my, b: it_q.my};
          ret_q   <= ST_SQ2;
          state_q <= ST_WAIT;
        end
        ST_SQ2: begin
          s_q     <= s_q + mul_rsp_i.prod;
          mul_q   <= '{start: 1'b1, a: it_q.mz, b: it_q.mz};
          ret_q   <= ST_SQ3;
          state_q <= ST_WAIT;
        end
        ST_SQ3: begin
          sqrt_q  <= '{start: 1'b1, rad: s_q + mul_rsp_i.prod};
          ret_q   <= ST_RAD;
          state_q <= ST_WAIT;
        end
        ST_RAD: begin
          r_q <= sqrt_rsp_i.root;
          if (sqrt_rsp_i.root > {1'b0, cfg_i.radius}) begin
            state_q <= ST_FIN;
          end else begin
            mul_q   <= '{start: 1'b1, a: {1'b0, cfg_i.radius}, b: {1'b0, cfg_i.radius}};
            ret_q   <= ST_HH;
            state_q <= ST_WAIT;
          end
        end
        ST_HH: begin
          ovf_q   <= ovf_q | fm_sat;
          tmp_q   <= fm;
          mul_q   <= '{start: 1'b1, a: r_q, b: r_q};
          ret_q   <= ST_RR;
          state_q <= ST_WAIT;
        end
        ST_RR: begin
          ovf_q   <= ovf_q | fm_sat;
          d_q     <= d_now;
          mul_q   <= '{start: 1'b1, a: {1'b0, d_now}, b: {1'b0, d_now}};
          ret_q   <= ST_D2;
          state_q <= ST_WAIT;
        end
        ST_D2: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: fm_w, b: {1'b0, d_q}};
          ret_q   <= ST_D3;
          state_q <= ST_WAIT;
        end
        ST_D3: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: {1'b0, cfg_i.poly6}, b: fm_w};
          ret_q   <= ST_PW;
          state_q <= ST_WAIT;
        end
        ST_PW: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: {1'b0, it_q.mass}, b: fm_w};
          ret_q   <= ST_DM;
          state_q <= ST_WAIT;
        end
        ST_DM: begin
          ovf_q  <= ovf_q | fm_sat | add_d.sat;
          dsum_q <= add_d.val;
          // self and zero distance neighbours add density only
          if (!it_q.is_self && (r_q != '0)) begin
            mul_q   <= '{start: 1'b1, a: {1'b0, hr}, b: {1'b0, hr}};
            ret_q   <= ST_HR;
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_HR: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: {1'b0, cfg_i.spiky}, b: fm_w};
          ret_q   <= ST_SC;
          state_q <= ST_WAIT;
        end
        ST_SC: begin
          ovf_q   <= ovf_q | fm_sat;
          div_q   <= '{start: 1'b1, num: fm_w, den: den_now};
          ret_q   <= ST_QT;
          state_q <= ST_WAIT;
        end
        ST_QT: begin
          ovf_q   <= ovf_q | div_rsp_i.sat;
          q_q     <= div_rsp_i.quo;
          mul_q   <= '{start: 1'b1, a: it_q.mx, b: {1'b0, div_rsp_i.quo}};
          ret_q   <= ST_GX1;
          state_q <= ST_WAIT;
        end
        ST_GX1, ST_GY1, ST_GZ1, ST_A1: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: {1'b0, it_q.mass}, b: fm_w};
          state_q <= ST_WAIT;
          case (state_q)
            ST_GX1:  ret_q <= ST_GX2;
            ST_GY1:  ret_q <= ST_GY2;
            ST_GZ1:  ret_q <= ST_GZ2;
            default: ret_q <= ST_A2;
          endcase
        end
        ST_GX2: begin
          ovf_q   <= ovf_q | fm_sat | add_x.sat;
          gsx_q   <= add_x.val;
          mul_q   <= '{start: 1'b1, a: it_q.my, b: {1'b0, q_q}};
          ret_q   <= ST_GY1;
          state_q <= ST_WAIT;
        end
        ST_GY2: begin
          ovf_q   <= ovf_q | fm_sat | add_y.sat;
          gsy_q   <= add_y.val;
          mul_q   <= '{start: 1'b1, a: it_q.mz, b: {1'b0, q_q}};
          ret_q   <= ST_GZ1;
          state_q <= ST_WAIT;
        end
        ST_GZ2: begin
          ovf_q   <= ovf_q | fm_sat | add_z.sat;
          gsz_q   <= add_z.val;
          mul_q   <= '{start: 1'b1, a: r_q, b: {1'b0, q_q}};
          ret_q   <= ST_A1;
          state_q <= ST_WAIT;
        end
        ST_A2: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: fm_w, b: {1'b0, cfg_i.inv_rest}};
          ret_q   <= ST_A3;
          state_q <= ST_WAIT;
        end
        ST_A3: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: fm_w, b: fm_w};
          ret_q   <= ST_A4;
          state_q <= ST_WAIT;
        end
        ST_A4: begin
          ovf_q   <= ovf_q | fm_sat | add_g.sat;
          gss_q   <= add_g.val;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (it_q.last_neighbor) begin
            mul_q   <= '{start: 1'b1, a: abs_word(gsx_q), b: abs_word(gsx_q)};
            ret_q   <= ST_G1;
            state_q <= ST_WAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_G1: begin
          s_q     <= mul_rsp_i.prod;
          mul_q   <= '{start: 1'b1, a: abs_word(gsy_q), b: abs_word(gsy_q)};
          ret_q   <= ST_G2;
          state_q <= ST_WAIT;
        end
        ST_G2: begin
          s_q     <= s_q + mul_rsp_i.prod;
          mul_q   <= '{start: 1'b1, a: abs_word(gsz_q), b: abs_word(gsz_q)};
          ret_q   <= ST_G3;
          state_q <= ST_WAIT;
        end
        ST_G3: begin
          sqrt_q  <= '{start: 1'b1, rad: s_q + mul_rsp_i.prod};
          ret_q   <= ST_GM;
          state_q <= ST_WAIT;
        end
        ST_GM: begin
          ovf_q   <= ovf_q | gm_sat;
          mul_q   <= '{start: 1'b1, a: {1'b0, cfg_i.inv_rest}, b: {1'b0, gm}};
          ret_q   <= ST_GG;
          state_q <= ST_WAIT;
        end
        ST_GG: begin
          ovf_q   <= ovf_q | fm_sat;
          mul_q   <= '{start: 1'b1, a: fm_w, b: fm_w};
          ret_q   <= ST_GS;
          state_q <= ST_WAIT;
        end
        ST_GS: begin
          ovf_q   <= ovf_q | fm_sat | add_g.sat | add_s2.sat;
          denom_q <= add_s2.val[W-1] ? '0 : add_s2.val[MW-1:0];
          mul_q   <= '{start: 1'b1, a: {1'b0, dens}, b: {1'b0, cfg_i.inv_rest}};
          ret_q   <= ST_CD;
          state_q <= ST_WAIT;
        end
        ST_CD: begin
          lneg_q <= !c_val[W-1] && (c_val != '0);
          if (denom_q == '0) begin
            // zero denominator: clamp unless the constraint is met exactly
            ovf_q   <= ovf_q | fm_sat | add_c.sat | (cm != '0);
            lm_q    <= (cm == '0) ? '0 : MAGMAX;
            state_q <= ST_EMIT;
          end else begin
            ovf_q   <= ovf_q | fm_sat | add_c.sat;
            div_q   <= '{start: 1'b1, num: cm, den: denom_q};
            ret_q   <= ST_LD;
            state_q <= ST_WAIT;
          end
        end
        ST_LD: begin
          ovf_q   <= ovf_q | div_rsp_i.sat;
          lm_q    <= div_rsp_i.quo;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          lambda_q    <= lneg_q ? (~{1'b0, lm_q} + word_t'(1)) : {1'b0, lm_q};
          density_q   <= dens;
          sat_q       <= ovf_q;
          res_valid_q <= 1'b1;
          dsum_q      <= '0;
          gsx_q       <= '0;
          gsy_q       <= '0;
          gsz_q       <= '0;
          gss_q       <= '0;
          ovf_q       <= 1'b0;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign mul_req_o   = mul_q;
  assign sqrt_req_o  = sqrt_q;
  assign div_req_o   = div_q;
  assign res_valid_o = res_valid_q;
  assign lambda_o    = lambda_q;
  assign density_o   = density_q;
  assign saturated_o = sat_q;

endmodule

// ----- hdl/fluid_density_constraint_lambda_unit.sv -----
// top level of the density constraint lambda unit: config registers, front, back, shared units
// depends on fdcl_pkg, fdcl_front, fdcl_mul, fdcl_sqrt, fdcl_div, fdcl_back
//
//  channel    handshake              payload
//  neighbour  start / busy           rel_x/y/z_i, neighbor_mass_i, is_self_i, last_neighbor_i
//  result     result_valid_o strobe  lambda_value_o, density_value_o, saturated_o
//  config     cfg_valid / cfg_ready  cfg_index_i, cfg_data_i
//
// a neighbour inside the radius and away from itself takes 21 multiplies, a square root and
// a divide; one outside the radius stops after the square root, and the self or zero distance
// entry stops after the density sum
// the last neighbour adds the gradient norm, square root and divide
// a two-beat queue takes new neighbours while the back end works; busy means it is full
// reset clears the accumulators and restores register defaults; no clearing pass
// results come as a one-cycle strobe; the receiver cannot stall them

module fluid_density_constraint_lambda_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [fdcl_pkg::W-1:0]     rel_x_i,
  input  logic signed [fdcl_pkg::W-1:0]     rel_y_i,
  input  logic signed [fdcl_pkg::W-1:0]     rel_z_i,
  input  logic [fdcl_pkg::MW-1:0]           neighbor_mass_i,
  input  logic                              is_self_i,
  input  logic                              last_neighbor_i,
  output logic                              result_valid_o,
  output logic signed [fdcl_pkg::W-1:0]     lambda_value_o,
  output logic [fdcl_pkg::MW-1:0]           density_value_o,
  output logic                              saturated_o,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fdcl_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [fdcl_pkg::MW-1:0]           cfg_data_i
);
  import fdcl_pkg::*;

  cfg_t      cfg_q;
  item_t     head;
  logic      head_valid, pop;
  mul_req_t  mul_req;
  mul_rsp_t  mul_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  word_t     lambda_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius   <= RST_RADIUS;
      cfg_q.poly6    <= RST_POLY6;
      cfg_q.spiky    <= RST_SPIKY;
      cfg_q.inv_rest <= RST_INV_REST;
      cfg_q.epsilon  <= RST_EPSILON;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        REG_RADIUS:   cfg_q.radius   <= cfg_data_i;
        REG_POLY6:    cfg_q.poly6    <= cfg_data_i;
        REG_SPIKY:    cfg_q.spiky    <= cfg_data_i;
        REG_INV_REST: cfg_q.inv_rest <= cfg_data_i;
        REG_EPSILON:  cfg_q.epsilon  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fdcl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .rel_x_i         (rel_x_i),
    .rel_y_i         (rel_y_i),
    .rel_z_i         (rel_z_i),
    .mass_i          (neighbor_mass_i),
    .is_self_i       (is_self_i),
    .last_neighbor_i (last_neighbor_i),
    .head_o          (head),
    .head_valid_o    (head_valid),
    .pop_i           (pop)
  );

  fdcl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fdcl_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  fdcl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  fdcl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .mul_req_o    (mul_req),
    .mul_rsp_i    (mul_rsp),
    .sqrt_req_o   (sqrt_req),
    .sqrt_rsp_i   (sqrt_rsp),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .res_valid_o  (result_valid_o),
    .lambda_o     (lambda_w),
    .density_o    (density_value_o),
    .saturated_o  (saturated_o)
  );

  assign lambda_value_o = lambda_w;

  // only one shared unit works at a time
  a_one_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_rsp.done, sqrt_rsp.done, div_rsp.done}))
    else $error("two arithmetic units finished together");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beats back to back");

  // lambda magnitude is clamped, so the most negative word never appears
  a_lambda_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (lambda_w != {1'b1, {MW{1'b0}}}))
    else $error("lambda outside the clamped range");

endmodule
